>>> rtl/core/scad_pkg.sv
// Package with the shared types and constants of the sprite column attribute decoder.
package scad_pkg;

	typedef enum logic [1:0] {
		CFG_SCREEN_FLIPPED   = 2'd0,
		CFG_FLIP_ON_VERTICAL = 2'd1,
		CFG_ATTRIBUTE_FORMAT = 2'd2
	} cfg_index_t;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	localparam logic FORMAT_FIRST  = 1'b0;
	localparam logic FORMAT_SECOND = 1'b1;

	localparam logic [14:0] TILE_LAST = 15'h5fff;
	localparam logic signed [9:0] FLIP_AXIS = 10'sd240;
	localparam logic signed [10:0] Y_STEP = 11'sd16;
	localparam logic signed [10:0] Y_HIGH = 11'sd256;
	localparam logic signed [10:0] Y_LOW = -11'sd256;
	localparam logic signed [10:0] Y_SPAN = 11'sd512;

endpackage

>>> rtl/core/sprite_column_attribute_decoder.sv
// Top level of the sprite column attribute decoder.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   kind, first_word, second_word
// out      output     out_valid/out_stall tile_code, palette_index, mirror_x, mirror_y,
//                                         pos_x, pos_y
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A transaction passes the input register and then the result register, where its result
// is offered; one transaction is taken in every cycle while no stalled result holds the input register.
// The column state is updated when an item leaves the input register.
// Reset clears the column state, the configuration registers and both valid flags, not the payload.
// A stalled result holds only the input register, and only when that item yields a result.
module sprite_column_attribute_decoder
	import scad_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [15:0]        first_word,
	input  logic [15:0]        second_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        tile_code,
	output logic [6:0]         palette_index,
	output logic               mirror_x,
	output logic               mirror_y,
	output logic signed [9:0]  pos_x,
	output logic signed [9:0]  pos_y
);

	logic screen_flipped_q;
	logic flip_on_vertical_q;
	logic attribute_format_q;

	logic signed [9:0] column_x_q;
	logic signed [9:0] column_y_q;
	logic              column_ended_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] first_word_s1;
	logic [15:0] second_word_s1;

	logic              out_valid_q;
	logic [14:0]       tile_code_q;
	logic [6:0]        palette_index_q;
	logic              mirror_x_q;
	logic              mirror_y_q;
	logic signed [9:0] pos_x_q;
	logic signed [9:0] pos_y_q;

	logic              is_entry;
	logic [6:0]        color;
	logic              tile_over;
	logic              ends_column;
	logic              produce;
	logic              steps_y;
	logic              leave_s1;
	logic [14:0]       tile_d;
	logic              mirror_x_d;
	logic              mirror_y_d;
	logic signed [9:0] head_x;
	logic signed [9:0] head_y;
	logic signed [9:0] head_x_d;
	logic signed [9:0] head_y_d;
	logic signed [10:0] y_wide;
	logic signed [10:0] y_moved;
	logic signed [10:0] y_wrapped;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_flipped_q   <= 1'b0;
			flip_on_vertical_q <= 1'b0;
			attribute_format_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCREEN_FLIPPED:   screen_flipped_q   <= cfg_data;
				CFG_FLIP_ON_VERTICAL: flip_on_vertical_q <= cfg_data;
				CFG_ATTRIBUTE_FORMAT: attribute_format_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Both formats keep the same nine low bits of the coarse and fine x.
	always_comb begin
		head_x = {first_word_s1[4], first_word_s1[4:0], second_word_s1[15:12]};
		head_y = 10'sd0 - {second_word_s1[8], second_word_s1[8:0]};
		head_x_d = screen_flipped_q ? FLIP_AXIS - head_x : head_x;
		head_y_d = screen_flipped_q ? FLIP_AXIS - head_y : head_y;
	end

	always_comb begin
		is_entry = valid_s1 && (kind_s1 == KIND_ENTRY) && !column_ended_q;
		color = first_word_s1[6:0];
		tile_over = second_word_s1[14:0] > TILE_LAST;
		ends_column = is_entry && (color != 7'd0) &&
			(attribute_format_q == FORMAT_SECOND) && tile_over;
		produce = is_entry && (color != 7'd0) && !ends_column;
		steps_y = is_entry && !ends_column;
		leave_s1 = valid_s1 && !(produce && out_valid_q && out_stall);
		in_stall = valid_s1 && !leave_s1;
	end

	always_comb begin
		if (attribute_format_q == FORMAT_FIRST) begin
			tile_d = {1'b0, second_word_s1[13:0]};
			mirror_x_d = second_word_s1[14];
			mirror_y_d = second_word_s1[15];
		end else begin
			tile_d = second_word_s1[14:0];
			mirror_x_d = flip_on_vertical_q ? 1'b0 : second_word_s1[15];
			mirror_y_d = flip_on_vertical_q ? second_word_s1[15] : 1'b0;
		end
	end

	always_comb begin
		y_wide = {column_y_q[9], column_y_q};
		y_moved = screen_flipped_q ? y_wide - Y_STEP : y_wide + Y_STEP;
		if (!screen_flipped_q && (y_moved > Y_HIGH)) begin
			y_wrapped = y_moved - Y_SPAN;
		end else if (screen_flipped_q && (y_moved < Y_LOW)) begin
			y_wrapped = y_moved + Y_SPAN;
		end else begin
			y_wrapped = y_moved;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1        <= kind;
			first_word_s1  <= first_word;
			second_word_s1 <= second_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_x_q     <= 10'sd0;
			column_y_q     <= 10'sd0;
			column_ended_q <= 1'b0;
		end else if (leave_s1) begin
			if (kind_s1 == KIND_HEADER) begin
				column_x_q     <= head_x_d;
				column_y_q     <= head_y_d;
				column_ended_q <= 1'b0;
			end else begin
				if (steps_y) begin
					column_y_q <= y_wrapped[9:0];
				end
				if (ends_column) begin
					column_ended_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave_s1 && produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1 && produce) begin
			tile_code_q     <= tile_d;
			palette_index_q <= color;
			mirror_x_q      <= mirror_x_d ^ screen_flipped_q;
			mirror_y_q      <= mirror_y_d ^ screen_flipped_q;
			pos_x_q         <= column_x_q;
			pos_y_q         <= column_y_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign tile_code     = tile_code_q;
	assign palette_index = palette_index_q;
	assign mirror_x      = mirror_x_q;
	assign mirror_y      = mirror_y_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;

endmodule

>>> rtl/core/scad_checker.sv
// Port checker for the sprite column attribute decoder and its bind statement.
module scad_checker
	import scad_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [14:0]        tile_code,
	input logic [6:0]         palette_index,
	input logic signed [9:0]  pos_x
);

	// A stalled result transaction stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result withdrawn while stalled.");

	// A stalled result transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(tile_code) && $stable(palette_index) &&
			$stable(pos_x))
		else $error("Result payload changed while stalled.");

	// The input side is held back only by a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("Input stalled while the output is free.");

	// An entry with color zero never becomes a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> palette_index != 7'd0)
		else $error("Result with color zero.");

	// Column end codes never reach the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tile_code <= TILE_LAST)
		else $error("Result with a tile code past the last tile.");

endmodule

bind sprite_column_attribute_decoder scad_checker u_scad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.tile_code     (tile_code),
	.palette_index (palette_index),
	.pos_x         (pos_x)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sprite column attribute decoder with its own decode of the stream.
module tb_top;
	import scad_pkg::*;

	typedef struct packed {
		logic [14:0] tile;
		logic [6:0]  color;
		logic        fx;
		logic        fy;
		logic [9:0]  px;
		logic [9:0]  py;
	} draw_cmd_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 2'd0;
	logic               cfg_data = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = 1'b0;
	logic [15:0]        first_word = 16'd0;
	logic [15:0]        second_word = 16'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [14:0]        tile_code;
	logic [6:0]         palette_index;
	logic               mirror_x;
	logic               mirror_y;
	logic signed [9:0]  pos_x;
	logic signed [9:0]  pos_y;

	logic               screen_flip = 1'b0;
	logic               vertical_flip_bit = 1'b0;
	logic               format_sel = FORMAT_FIRST;
	logic signed [9:0]  track_x = 10'sd0;
	logic signed [9:0]  track_y = 10'sd0;
	logic               track_ended = 1'b0;

	draw_cmd_t          expected_draws[$];
	draw_cmd_t          oldest_draw;
	int                 mismatches = 0;
	int                 items_sent = 0;
	bit                 send_gaps = 1'b1;
	bit                 stall_random = 1'b1;
	int                 hold_request = 0;
	int                 stall_left = 0;

	sprite_column_attribute_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.first_word(first_word),
		.second_word(second_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tile_code(tile_code),
		.palette_index(palette_index),
		.mirror_x(mirror_x),
		.mirror_y(mirror_y),
		.pos_x(pos_x),
		.pos_y(pos_y)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int wrap_nine(int v);
		return ((v + 256) & 511) - 256;
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic decode_attribute(logic k, logic [15:0] w1, logic [15:0] w2);
		int x;
		int y;
		logic fx;
		logic fy;
		logic [14:0] tile;
		draw_cmd_t cmd;
		if (k == KIND_HEADER) begin
			if (format_sel == FORMAT_FIRST) begin
				x = (int'(w1[7:0]) << 4) + int'(w2[15:12]);
				x = ((x + 16) & 511) - 16;
			end else begin
				x = (int'(w1) << 4) | int'(w2[15:12]);
			end
			x = wrap_nine(x);
			y = -wrap_nine(int'(w2));
			if (screen_flip) begin
				x = 240 - x;
				y = 240 - y;
			end
			track_x = x[9:0];
			track_y = y[9:0];
			track_ended = 1'b0;
			return;
		end
		if (track_ended)
			return;
		if (w1[6:0] != 7'd0) begin
			if (format_sel == FORMAT_FIRST) begin
				fy = w2[15];
				fx = w2[14];
				tile = {1'b0, w2[13:0]};
			end else begin
				fx = vertical_flip_bit ? 1'b0 : w2[15];
				fy = vertical_flip_bit ? w2[15] : 1'b0;
				tile = w2[14:0];
				if (tile > TILE_LAST) begin
					track_ended = 1'b1;
					return;
				end
			end
			cmd.tile = tile;
			cmd.color = w1[6:0];
			cmd.fx = fx ^ screen_flip;
			cmd.fy = fy ^ screen_flip;
			cmd.px = track_x;
			cmd.py = track_y;
			expected_draws.push_back(cmd);
		end
		y = track_y;
		if (screen_flip) begin
			y = y - 16;
			if (y < -256)
				y = y + 512;
		end else begin
			y = y + 16;
			if (y > 256)
				y = y - 512;
		end
		track_y = y[9:0];
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_draws.size() == 0) begin
				$display("%0t: unexpected draw command, expected none actual tile %0d",
					$time, tile_code);
				mismatches++;
			end else begin
				oldest_draw = expected_draws.pop_front();
				check_field("tile_code", oldest_draw.tile, tile_code);
				check_field("palette_index", oldest_draw.color, palette_index);
				check_field("mirror_x", oldest_draw.fx, mirror_x);
				check_field("mirror_y", oldest_draw.fy, mirror_y);
				check_field("pos_x", $signed(oldest_draw.px), pos_x);
				check_field("pos_y", $signed(oldest_draw.py), pos_y);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_random && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = pick_gap() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(logic k, logic [15:0] w1, logic [15:0] w2);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		first_word <= w1;
		second_word <= w2;
		do @(posedge clk); while (in_stall);
		decode_attribute(k, w1, w2);
		items_sent++;
		gap = (send_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, logic value);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SCREEN_FLIPPED: screen_flip = value;
			CFG_FLIP_ON_VERTICAL: vertical_flip_bit = value;
			CFG_ATTRIBUTE_FORMAT: format_sel = value;
			default: ;
		endcase
	endtask

	task automatic test_entry_before_header();
		send_item(KIND_ENTRY, 16'h007f, 16'hffff);
		send_item(KIND_ENTRY, 16'hff80, 16'h0000);
	endtask

	task automatic test_first_format();
		send_item(KIND_HEADER, 16'hffff, 16'hffff);
		send_item(KIND_ENTRY, 16'h007f, 16'hffff);
		send_item(KIND_HEADER, 16'h0000, 16'h0000);
		send_item(KIND_ENTRY, 16'h0001, 16'h0000);
		send_item(KIND_ENTRY, 16'hff80, 16'h4000);
		send_item(KIND_HEADER, 16'h0000, 16'h0100);
		send_item(KIND_ENTRY, 16'h0002, 16'h8000);
		send_item(KIND_ENTRY, 16'h0003, 16'h7fff);
	endtask

	task automatic test_second_format();
		write_register(CFG_ATTRIBUTE_FORMAT, FORMAT_SECOND);
		send_item(KIND_HEADER, 16'hffff, 16'hffff);
		send_item(KIND_ENTRY, 16'h0001, 16'h5fff);
		send_item(KIND_ENTRY, 16'hff80, 16'h6000);
		send_item(KIND_ENTRY, 16'h007f, 16'h8000);
		send_item(KIND_ENTRY, 16'h0005, 16'hffff);
		send_item(KIND_ENTRY, 16'h0001, 16'h0001);
		send_item(KIND_HEADER, 16'h0000, 16'h0000);
		send_item(KIND_ENTRY, 16'h007f, 16'h6000);
		send_item(KIND_HEADER, 16'h1234, 16'habcd);
		send_item(KIND_ENTRY, 16'h0011, 16'h8123);
	endtask

	task automatic test_flip_settings();
		write_register(CFG_FLIP_ON_VERTICAL, 1'b1);
		write_register(CFG_SCREEN_FLIPPED, 1'b1);
		send_item(KIND_HEADER, 16'h00ff, 16'hf0ff);
		send_item(KIND_ENTRY, 16'h0042, 16'h8001);
		send_item(KIND_ENTRY, 16'h0001, 16'h0fff);
		// The stored position must survive a flip change in the middle of a column.
		write_register(CFG_SCREEN_FLIPPED, 1'b0);
		send_item(KIND_ENTRY, 16'h0003, 16'h8002);
	endtask

	task automatic send_random_column();
		int len;
		int i;
		logic [15:0] w1;
		logic [15:0] w2;
		if ($urandom_range(0, 9) != 0)
			send_item(KIND_HEADER, pick_word(), pick_word());
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(1'($urandom_range(0, 1)), pick_word(), pick_word());
			end else begin
				w1 = 16'($urandom);
				w1[6:0] = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
				w2 = 16'($urandom);
				if (format_sel == FORMAT_SECOND && $urandom_range(0, 15) != 0)
					w2[14:0] = 15'($urandom_range(0, TILE_LAST));
				send_item(KIND_ENTRY, w1, w2);
			end
		end
	endtask

	task automatic test_random_columns();
		int phase;
		int goal;
		int total_goal;
		logic [2:0] setting;
		total_goal = items_sent + 1280;
		for (phase = 0; items_sent < total_goal; phase++) begin
			setting = (phase < 8) ? 3'(phase) : 3'($urandom);
			write_register(CFG_SCREEN_FLIPPED, setting[0]);
			write_register(CFG_FLIP_ON_VERTICAL, setting[1]);
			write_register(CFG_ATTRIBUTE_FORMAT, setting[2]);
			send_gaps = (phase % 4 != 3);
			stall_random = send_gaps;
			goal = items_sent + 150;
			while (items_sent < goal)
				send_random_column();
		end
		send_gaps = 1'b1;
		stall_random = 1'b1;
	endtask

	task automatic test_backpressure();
		int i;
		write_register(CFG_ATTRIBUTE_FORMAT, FORMAT_FIRST);
		send_gaps = 1'b0;
		send_item(KIND_HEADER, pick_word(), pick_word());
		hold_request = 80;
		for (i = 0; i < 50; i++)
			send_item(KIND_ENTRY, {9'($urandom), 7'($urandom_range(1, 127))}, 16'($urandom));
		send_gaps = 1'b1;
		wait_for_drain();
		for (i = 0; i < 30; i++)
			send_item(KIND_ENTRY, {9'($urandom), 7'($urandom_range(1, 127))}, 16'($urandom));
	endtask

	initial begin
		int waited;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_entry_before_header();
		test_first_format();
		test_second_format();
		test_flip_settings();
		test_random_columns();
		test_backpressure();
		in_valid <= 1'b0;
		waited = 0;
		while (expected_draws.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_draws.size() != 0) begin
			$display("%0t: expected %0d more draw commands, actual none", $time,
				expected_draws.size());
			mismatches++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
